/* src/stqs_pkg.sv */
`timescale 1ns / 1ps
// Package for the sojourn time queue sizer: field widths, register reset values,
// register indexes, queue entry and configuration types, back-end state codes.
// No dependencies.
package stqs_pkg;

	localparam int SOJ_W      = 24;
	localparam int SUM_W      = 48;
	localparam int CNT_W      = 24;
	localparam int FACTOR_W   = 16;
	localparam int CFG_SIZE_W = 16;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	localparam int DEF_SIZE_BITS   = 16;
	localparam int DEF_TIME_BITS   = 48;
	localparam int DEF_QUEUE_DEPTH = 2;

	localparam int SIZE_RESET = 10;

	localparam logic [23:0] INTERVAL_RESET = 24'd200000;
	localparam logic [23:0] TARGET_RESET   = 24'd7000;
	localparam logic [15:0] MIN_RESET      = 16'd2;
	localparam logic [15:0] MAX_RESET      = 16'd20;
	localparam logic [15:0] FACTOR_RESET   = 16'd6554;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERVAL    = 3'd0,
		REG_TARGET      = 3'd1,
		REG_SIZE_FLOOR  = 3'd2,
		REG_SIZE_CEIL   = 3'd3,
		REG_STEP_FACTOR = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [23:0]           interval_us;
		logic [23:0]           target_us;
		logic [CFG_SIZE_W-1:0] size_floor;
		logic [CFG_SIZE_W-1:0] size_ceil;
		logic [FACTOR_W-1:0]   step_factor;
	} cfg_t;

	// One classified report, handed from the front end to the back end.
	typedef struct packed {
		logic             closes;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} q_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_AVG,
		ST_DECIDE,
		ST_MUL_STEP,
		ST_APPLY
	} back_state_t;

endpackage

/* src/stqs_fifo.sv */
`timescale 1ns / 1ps
// Short register queue that carries classified reports from front to back end.
// Depends on stqs_pkg for the entry type.
module stqs_fifo import stqs_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     not_empty,
	output q_entry_t pop_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("queue written while full");

endmodule

/* src/stqs_front.sv */
`timescale 1ns / 1ps
// Front end: captures reports, keeps the interval sum, count and start time,
// and decides whether each report closes an interval. Depends on stqs_pkg.
module stqs_front import stqs_pkg::*; #(
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SOJ_W-1:0]     sojourn_us,
	input  logic [TIME_BITS-1:0] now_us,
	input  logic [23:0]          interval_us,
	output logic                 push,
	output q_entry_t             push_data,
	input  logic                 full
);

	logic                 hold_q;
	logic [SOJ_W-1:0]     soj_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     count_q;
	logic [TIME_BITS-1:0] start_q;

	logic [SUM_W:0]       sum_wide;
	logic [SUM_W-1:0]     sum_new;
	logic [CNT_W-1:0]     count_new;
	logic [TIME_BITS-1:0] elapsed;
	logic                 closes;

	assign push     = hold_q && !full;
	assign in_ready = !hold_q || push;

	always_comb begin
		sum_wide  = {1'b0, sum_q} + (SUM_W + 1)'(soj_s1);
		sum_new   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
		count_new = (count_q == '1) ? count_q : count_q + 1'b1;
		elapsed   = now_s1 - start_q;
		closes    = (elapsed >= TIME_BITS'(interval_us));
	end

	assign push_data = '{closes: closes, sum: sum_new, count: count_new};

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			soj_s1 <= sojourn_us;
			now_s1 <= now_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= 1'b0;
			sum_q   <= '0;
			count_q <= '0;
			start_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				hold_q <= 1'b1;
			end else if (push) begin
				hold_q <= 1'b0;
			end
			if (push) begin
				if (closes) begin
					sum_q   <= '0;
					count_q <= '0;
					start_q <= now_s1;
				end else begin
					sum_q   <= sum_new;
					count_q <= count_new;
				end
			end
		end
	end

endmodule

/* src/stqs_back.sv */
`timescale 1ns / 1ps
// Back end: holds the queue size, runs the average test and the size step on a
// shared sequence of multiply cycles, and owns the result register. Depends on stqs_pkg.
module stqs_back import stqs_pkg::*; #(
	parameter int SIZE_BITS = DEF_SIZE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 not_empty,
	input  q_entry_t             pop_data,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SIZE_BITS-1:0] queue_size,
	output logic                 adjusted,
	output logic                 shrank
);

	// Size arithmetic runs wide enough for both the size and the bounds.
	localparam int WW = (SIZE_BITS > CFG_SIZE_W) ? SIZE_BITS : CFG_SIZE_W;
	localparam int PW = FACTOR_W + WW;

	back_state_t          state_q, state_d;
	logic [SIZE_BITS-1:0] size_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     avg_prod_q;
	logic                 shrink_q;
	logic [WW-1:0]        span_q;
	logic [PW-1:0]        step_prod_q;
	logic                 out_valid_q;
	logic [SIZE_BITS-1:0] out_size_q;
	logic                 out_adj_q;
	logic                 out_shr_q;

	logic start, load_plain, capture, do_avg, do_decide, do_step, do_apply;

	logic [WW-1:0]        size_w, min_w, max_w;
	logic                 shrink_d;
	logic [WW-1:0]        span_d;
	logic [PW:0]          up_sum;
	logic [WW:0]          step;
	logic [WW:0]          size_e, min_e, max_e, diff, grow_sum, nsize;
	logic [SIZE_BITS-1:0] size_new;

	assign start = not_empty && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (start && pop_data.closes) state_d = ST_MUL_AVG;
			ST_MUL_AVG:  state_d = ST_DECIDE;
			ST_DECIDE:   state_d = ST_MUL_STEP;
			ST_MUL_STEP: state_d = ST_APPLY;
			ST_APPLY:    state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		load_plain = 1'b0;
		capture    = 1'b0;
		do_avg     = 1'b0;
		do_decide  = 1'b0;
		do_step    = 1'b0;
		do_apply   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop        = start;
				capture    = start && pop_data.closes;
				load_plain = start && !pop_data.closes;
			end
			ST_MUL_AVG:  do_avg    = 1'b1;
			ST_DECIDE:   do_decide = 1'b1;
			ST_MUL_STEP: do_step   = 1'b1;
			ST_APPLY:    do_apply  = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		size_w   = WW'(size_q);
		min_w    = WW'(cfg.size_floor);
		max_w    = WW'(cfg.size_ceil);
		shrink_d = (sum_q > avg_prod_q);
		if (shrink_d) begin
			span_d = (size_w > min_w) ? size_w - min_w : '0;
		end else begin
			span_d = (max_w > size_w) ? max_w - size_w : '0;
		end

		// Shrinking rounds the step up, growing rounds it down; never below one.
		up_sum = {1'b0, step_prod_q} + (PW + 1)'(16'hFFFF);
		step   = shrink_q ? up_sum[PW:FACTOR_W] : {1'b0, step_prod_q[PW-1:FACTOR_W]};
		if (step == '0) begin
			step = (WW + 1)'(1);
		end

		size_e   = (WW + 1)'(size_q);
		min_e    = (WW + 1)'(cfg.size_floor);
		max_e    = (WW + 1)'(cfg.size_ceil);
		diff     = size_e - step;
		grow_sum = size_e + step;
		if (shrink_q) begin
			nsize = (size_e >= step && diff >= min_e) ? diff : min_e;
		end else begin
			nsize = (grow_sum > max_e) ? max_e : grow_sum;
		end
		size_new = nsize[SIZE_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			sum_q   <= pop_data.sum;
			count_q <= pop_data.count;
		end
		if (do_avg) begin
			avg_prod_q <= SUM_W'(cfg.target_us) * SUM_W'(count_q);
		end
		if (do_decide) begin
			shrink_q <= shrink_d;
			span_q   <= span_d;
		end
		if (do_step) begin
			step_prod_q <= PW'(cfg.step_factor) * PW'(span_q);
		end
		if (load_plain) begin
			out_size_q <= size_q;
			out_adj_q  <= 1'b0;
			out_shr_q  <= 1'b0;
		end else if (do_apply) begin
			out_size_q <= size_new;
			out_adj_q  <= 1'b1;
			out_shr_q  <= (size_new < size_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_q      <= SIZE_BITS'(SIZE_RESET);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_apply) begin
				size_q <= size_new;
			end
			if (load_plain || do_apply) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign queue_size = out_size_q;
	assign adjusted   = out_adj_q;
	assign shrank     = out_shr_q;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from an empty queue");

	a_apply_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_APPLY |-> !out_valid_q)
		else $error("result register busy when an adjustment completes");

	a_shrank_only_adj: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_adj_q |-> !out_shr_q)
		else $error("shrank flagged on a report that made no adjustment");

endmodule

/* src/sojourn_time_queue_sizer_core.sv */
`timescale 1ns / 1ps
// Top level of the sojourn time queue sizer: configuration registers and the
// front end, queue and back end. Depends on stqs_pkg, stqs_front, stqs_fifo, stqs_back.

// Each input transaction reports one packet's sojourn time together with the current
// microsecond time, and each one yields exactly one result transaction carrying the
// queue size after that report. The front end captures a report at the accepting edge
// and, once there is room, updates the saturating sum and count, tests the interval
// and pushes the classified report into a two-entry queue by default; its input is
// ready again as it pushes, so it takes one report per cycle unless the queue is full.
// A report that closes no interval is taken by the back end straight from idle, and its
// result, the unchanged queue size, is loaded into the output register. A report that
// closes an interval is taken, then runs the target times count multiply, the average
// compare, the factor times span multiply and the application of the new size, each in
// a state of its own. The short queue between the halves lets the front keep taking
// reports meanwhile. Sustained, the block takes one report per cycle while no interval
// closes, provided results are taken as they appear; a report that closes one holds
// the back end busy until its new size is applied. A result that is held stalls the
// back end, then the queue, then the input. A result waits in an output register while
// the next report is already accepted.
// Configuration writes are meant for idle periods only; the five registers take effect
// at once and reset to an interval of 200000 us, a target of 7000 us, sizes from 2 to 20
// and a step factor of about 0.1 in Q0.16. The queue size starts at 10 after reset.
module sojourn_time_queue_sizer_core import stqs_pkg::*; #(
	parameter int SIZE_BITS   = DEF_SIZE_BITS,
	parameter int TIME_BITS   = DEF_TIME_BITS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SOJ_W-1:0]      sojourn_us,
	input  logic [TIME_BITS-1:0]  now_us,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SIZE_BITS-1:0]  queue_size,
	output logic                  adjusted,
	output logic                  shrank
);

	cfg_t     cfg_q;
	logic     push, full, pop, not_empty;
	q_entry_t push_data, pop_data;

	// Writes to indexes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval_us <= INTERVAL_RESET;
			cfg_q.target_us   <= TARGET_RESET;
			cfg_q.size_floor  <= MIN_RESET;
			cfg_q.size_ceil   <= MAX_RESET;
			cfg_q.step_factor <= FACTOR_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_INTERVAL:    cfg_q.interval_us <= cfg_data;
				REG_TARGET:      cfg_q.target_us   <= cfg_data;
				REG_SIZE_FLOOR:  cfg_q.size_floor  <= cfg_data[CFG_SIZE_W-1:0];
				REG_SIZE_CEIL:   cfg_q.size_ceil   <= cfg_data[CFG_SIZE_W-1:0];
				REG_STEP_FACTOR: cfg_q.step_factor <= cfg_data[FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

	stqs_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sojourn_us (sojourn_us),
		.now_us     (now_us),
		.interval_us(cfg_q.interval_us),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	stqs_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.not_empty(not_empty),
		.pop_data (pop_data)
	);

	stqs_back #(
		.SIZE_BITS(SIZE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.not_empty (not_empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.queue_size(queue_size),
		.adjusted  (adjusted),
		.shrank    (shrank)
	);

endmodule
